>>> hw/rtl/i2rd_pkg.sv
// ----------------------------------------------------------------------------
// i2rd_pkg: shared constants for the integer to radix digit converter
// Field widths, radix limits and the ASCII encoding of a digit.
// ----------------------------------------------------------------------------
package i2rd_pkg;

  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned IN_W    = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;  // 'A'

  // Digit 0-9 maps to '0'-'9', digit 10-15 maps to 'A'-'F'.
  function automatic logic [CHAR_W-1:0] ascii_of_digit(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/i2rd_front.sv
// ----------------------------------------------------------------------------
// i2rd_front: request intake and classification
// Registers each incoming value, masks it to the working width, flags zero
// values and holds the radix register with its saturated effective value.
// ----------------------------------------------------------------------------
module i2rd_front #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [i2rd_pkg::IN_W-1:0]        in_value_i,
  input  logic                             cfg_valid_i,
  input  logic [i2rd_pkg::RADIX_W-1:0]     cfg_data_i,
  output logic                             push_valid_o,
  input  logic                             push_ready_i,
  output logic [VALUE_BITS:0]              push_entry_o,
  output logic [i2rd_pkg::RADIX_W-1:0]     radix_o
);

  logic                             valid_q;
  logic [VALUE_BITS-1:0]            value_q;
  logic                             zero_q;
  logic [i2rd_pkg::RADIX_W-1:0]     radix_q;
  logic [63:0]                      wide_value;
  logic [VALUE_BITS-1:0]            masked_value;

  assign wide_value   = {32'd0, in_value_i};
  assign masked_value = wide_value[VALUE_BITS-1:0];
  assign in_ready_o   = !valid_q || push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      radix_q <= i2rd_pkg::RADIX_RESET;
    end else begin
      if (in_valid_i && in_ready_o) begin
        valid_q <= 1'b1;
      end else if (push_ready_i) begin
        valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        radix_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      value_q <= masked_value;
      zero_q  <= (masked_value == '0);
    end
  end

  // Radix values below two or above sixteen saturate to the nearest limit.
  always_comb begin
    if (radix_q < i2rd_pkg::RADIX_MIN) begin
      radix_o = i2rd_pkg::RADIX_MIN;
    end else if (radix_q > i2rd_pkg::RADIX_MAX) begin
      radix_o = i2rd_pkg::RADIX_MAX;
    end else begin
      radix_o = radix_q;
    end
  end

  assign push_valid_o = valid_q;
  assign push_entry_o = {zero_q, value_q};

endmodule

>>> hw/rtl/i2rd_fifo.sv
// ----------------------------------------------------------------------------
// i2rd_fifo: two-entry queue between intake and conversion
// Lets the intake take a new request while the converter is still busy.
// ----------------------------------------------------------------------------
module i2rd_fifo #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/i2rd_back.sv
// ----------------------------------------------------------------------------
// i2rd_back: iterative radix conversion and digit output
// Divides by the radix eight quotient bits per cycle, stores each remainder
// and then plays the digits back most significant first.
// ----------------------------------------------------------------------------
module i2rd_back #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  logic [VALUE_BITS:0]            pop_entry_i,
  input  logic [i2rd_pkg::RADIX_W-1:0]   radix_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [i2rd_pkg::CHAR_W-1:0]    out_char_o,
  output logic                           out_last_o,
  output logic                           out_empty_o
);

  localparam int unsigned QW     = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned STEPS  = QW / 8;
  localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned AW     = $clog2(VALUE_BITS);
  localparam int unsigned CW     = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ZERO,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e                              state_q;
  logic [QW-1:0]                       quo_q;
  logic [i2rd_pkg::DIGIT_W-1:0]        rem_q;
  logic [STEP_W-1:0]                   step_q;
  logic [CW-1:0]                       count_q;
  logic [AW-1:0]                       idx_q;
  logic                                out_valid_q;
  logic [i2rd_pkg::CHAR_W-1:0]         out_char_q;
  logic                                out_last_q;
  logic                                out_empty_q;

  logic [i2rd_pkg::DIGIT_W-1:0]        digit_mem [VALUE_BITS];
  logic [i2rd_pkg::DIGIT_W-1:0]        rd_data_q;

  logic [QW-1:0]                       quo_d;
  logic [i2rd_pkg::DIGIT_W-1:0]        rem_d;
  logic [i2rd_pkg::RADIX_W-1:0]        part;
  logic                                out_free;
  logic                                last_step;
  logic                                digit_wr;
  logic                                beat_load;

  // Eight restoring division steps on a narrow partial remainder.
  always_comb begin
    part  = {1'b0, rem_q};
    quo_d = quo_q;
    for (int i = 0; i < 8; i++) begin
      part  = {part[i2rd_pkg::DIGIT_W-1:0], quo_d[QW-1]};
      quo_d = {quo_d[QW-2:0], 1'b0};
      if (part >= radix_i) begin
        part     = part - radix_i;
        quo_d[0] = 1'b1;
      end
    end
    rem_d = part[i2rd_pkg::DIGIT_W-1:0];
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign last_step   = (step_q == STEP_W'(STEPS - 1));
  assign digit_wr    = (state_q == ST_DIV) && last_step;
  assign pop_ready_o = (state_q == ST_IDLE);
  assign beat_load   = ((state_q == ST_ZERO) || (state_q == ST_EMIT)) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      quo_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
    end else begin
      if (beat_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_valid_i) begin
            quo_q   <= QW'(pop_entry_i[VALUE_BITS-1:0]);
            rem_q   <= '0;
            step_q  <= '0;
            count_q <= '0;
            state_q <= pop_entry_i[VALUE_BITS] ? ST_ZERO : ST_DIV;
          end
        end
        ST_DIV: begin
          quo_q <= quo_d;
          if (last_step) begin
            rem_q   <= '0;
            step_q  <= '0;
            count_q <= count_q + CW'(1);
            if ((quo_d == '0) || (count_q == CW'(VALUE_BITS - 1))) begin
              idx_q   <= count_q[AW-1:0];
              state_q <= ST_READ;
            end
          end else begin
            rem_q  <= rem_d;
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_ZERO: begin
          if (out_free) begin
            out_char_q  <= '0;
            out_last_q  <= 1'b1;
            out_empty_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_char_q  <= i2rd_pkg::ascii_of_digit(rd_data_q);
            out_last_q  <= (idx_q == '0);
            out_empty_q <= 1'b0;
            if (idx_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q - AW'(1);
              state_q <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Digit store: written least significant first, read back in reverse.
  always_ff @(posedge clk_i) begin
    if (digit_wr) begin
      digit_mem[count_q[AW-1:0]] <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= digit_mem[idx_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_empty_o = out_empty_q;

endmodule

>>> hw/rtl/integer_to_radix_digits_unit.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit: unsigned integer to base-N ASCII digits
// Converts each request to the digits of a configured radix, most
// significant first, one ASCII character per output transfer.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one 32-bit unsigned value per request; only its
// low VALUE_BITS bits are converted. The master stream returns one transfer
// per digit: tdata holds the ASCII character, tlast marks the least
// significant digit and tuser flags the single transfer given for a zero
// value (character code 0, tlast 1). The config channel writes the radix;
// values below 2 or above 16 saturate. It is always ready; the user must
// write it only while the unit is idle, as the unit does not enforce this.
// A request enters an input register and a two-entry queue, so new requests
// are taken while the converter works. Conversion divides by the radix eight
// quotient bits per cycle for each digit, writing each remainder to the
// registered digit store; playback then reads each digit from the store and
// loads it into the output register. The converter takes the next request
// only after its last digit has been loaded.
// Reset returns the radix to 10 and empties the queue and output register.
// When the receiver stalls, the output register holds its transfer, the
// converter waits, and the queue and then the input register fill, so
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // [31:0] value
  // Digit stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [6:0] digit_char, [7] zero fill
  output logic                          m_axis_tlast,   // last_digit
  output logic                          m_axis_tuser,   // [0] empty_result
  // Radix configuration.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [i2rd_pkg::RADIX_W-1:0]  cfg_data_i
);

  localparam int unsigned ENTRY_W = VALUE_BITS + 1;

  logic                                 front_valid;
  logic                                 front_ready;
  logic [ENTRY_W-1:0]                   front_entry;
  logic                                 queue_valid;
  logic                                 queue_ready;
  logic [ENTRY_W-1:0]                   queue_entry;
  logic [i2rd_pkg::RADIX_W-1:0]         radix;
  logic [i2rd_pkg::CHAR_W-1:0]          digit_char;

  // The radix register accepts a write in every cycle.
  assign cfg_ready_o = 1'b1;

  i2rd_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_value_i   (s_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (front_valid),
    .push_ready_i (front_ready),
    .push_entry_o (front_entry),
    .radix_o      (radix)
  );

  i2rd_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_entry),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_entry)
  );

  i2rd_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (queue_valid),
    .pop_ready_o (queue_ready),
    .pop_entry_i (queue_entry),
    .radix_i     (radix),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (digit_char),
    .out_last_o  (m_axis_tlast),
    .out_empty_o (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, digit_char};

endmodule
